### src/photon_event_packet_deframer_macros.svh
// assertion macros shared by the deframer modules
`ifndef PHOTON_EVENT_PACKET_DEFRAMER_MACROS_SVH
`define PHOTON_EVENT_PACKET_DEFRAMER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PEPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define PEPD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### src/pepd_pkg.sv
// types and constants of the photon event packet deframer
`timescale 1ns / 1ps
package pepd_pkg;

  localparam int unsigned PACKET_WORDS = 735;
  localparam int unsigned ROW_WORDS    = 3;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned COORD_W      = 13;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned IDX_W        = $clog2(PACKET_WORDS + 1);
  localparam int unsigned ROW_W        = $clog2(PACKET_WORDS / ROW_WORDS + 1);
  localparam int unsigned COL_W        = $clog2(ROW_WORDS);
  localparam int unsigned CMP_W        = (ROW_W > COUNT_W) ? ROW_W : COUNT_W;
  localparam int unsigned CAP_RAW      = PACKET_WORDS / ROW_WORDS - 1;
  localparam int unsigned CAPACITY     = (CAP_RAW > 255) ? 255 : CAP_RAW;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_COUNT = 3'd0,
    OP_SEQ   = 3'd1,
    OP_SKIP  = 3'd2,
    OP_X     = 3'd3,
    OP_Y     = 3'd4,
    OP_PULSE = 3'd5
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               last;
    logic [ROW_W-1:0]   row;
    logic [WORD_W-1:0]  word;
  } cmd_t;

endpackage

### src/photon_event_packet_deframer.sv
// photon event packet deframer top level
//
//   channel  | handshake          | beat
//   ---------+--------------------+-----------------------------------------------
//   words    | push / full        | word_i, first_i
//   results  | pop / empty        | kind_o, x_pos_o, y_pos_o, pulse_o, missed_o,
//            |                    | photons_o, clamped_o
//
// one word a cycle sustained while full stays low; a word's result passes through the queue, then the result register
// reset parks the position counter at word 0 and clears the expected sequence number
// a four-beat queue sits between the position tracker and the result register
// full rises only once that queue fills while a result waits unpopped
`timescale 1ns / 1ps
module photon_event_packet_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [pepd_pkg::WORD_W-1:0]  word_i,
  input  logic                         first_i,
  input  logic                         pop,
  output logic                         empty,
  output logic                         kind_o,
  output logic [pepd_pkg::COORD_W-1:0] x_pos_o,
  output logic [pepd_pkg::COORD_W-1:0] y_pos_o,
  output logic [pepd_pkg::WORD_W-1:0]  pulse_o,
  output logic [pepd_pkg::WORD_W-1:0]  missed_o,
  output logic [pepd_pkg::COUNT_W-1:0] photons_o,
  output logic                         clamped_o
);
  import pepd_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;

  pepd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .word_i     (word_i),
    .first_i    (first_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  pepd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (full),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd_out),
    .empty_o     (cmd_empty)
  );

  pepd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind_o),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .pulse_o     (pulse_o),
    .missed_o    (missed_o),
    .photons_o   (photons_o),
    .clamped_o   (clamped_o)
  );

endmodule

### src/pepd_front.sv
// front end: tracks word position and classifies each beat
`timescale 1ns / 1ps
`include "photon_event_packet_deframer_macros.svh"
module pepd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       full_i,
  input  logic [pepd_pkg::WORD_W-1:0] word_i,
  input  logic                       first_i,
  output logic                       cmd_push_o,
  output pepd_pkg::cmd_t             cmd_o
);
  import pepd_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [IDX_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             accept;
  logic             in_range;
  logic             is_last;

  assign pos      = first_i ? '0 : idx_q;
  assign col      = first_i ? '0 : col_q;
  assign row      = first_i ? '0 : row_q;
  assign accept   = push_i && !full_i;
  assign in_range = (pos != IDX_W'(PACKET_WORDS));
  assign is_last  = (pos == IDX_W'(PACKET_WORDS - 1));

  always_comb begin
    idx_d = idx_q;
    col_d = col_q;
    row_d = row_q;
    if (accept && in_range) begin
      idx_d = is_last ? IDX_W'(PACKET_WORDS) : pos + IDX_W'(1);
      if (col == COL_W'(ROW_WORDS - 1)) begin
        col_d = '0;
        row_d = row + ROW_W'(1);
      end else begin
        col_d = col + COL_W'(1);
        row_d = row;
      end
    end
  end

  always_comb begin
    cmd_o.last = is_last;
    cmd_o.row  = row;
    cmd_o.word = word_i;
    if (pos == IDX_W'(0)) begin
      cmd_o.op = OP_COUNT;
    end else if (pos == IDX_W'(1)) begin
      cmd_o.op = OP_SEQ;
    end else if (pos < IDX_W'(ROW_WORDS)) begin
      cmd_o.op = OP_SKIP;
    end else if (col == COL_W'(0)) begin
      cmd_o.op = OP_X;
    end else if (col == COL_W'(1)) begin
      cmd_o.op = OP_Y;
    end else begin
      cmd_o.op = OP_PULSE;
    end
  end

  // words past the end of a packet are dropped here
  assign cmd_push_o = accept && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      idx_q <= idx_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `PEPD_ASSERT(a_idx_range, idx_q <= IDX_W'(PACKET_WORDS), "word index past idle mark")
  `PEPD_ASSERT_NEXT(a_last_idles, cmd_push_o && cmd_o.last, idx_q == IDX_W'(PACKET_WORDS),
                    "packet end did not park the position counter")

endmodule

### src/pepd_queue.sv
// short command queue between front and back ends
`timescale 1ns / 1ps
`include "photon_event_packet_deframer_macros.svh"
module pepd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pepd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output pepd_pkg::cmd_t pop_data_o,
  output logic           empty_o
);
  import pepd_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W:0]   wr_q, wr_d;
  logic [QPTR_W:0]   rd_q, rd_d;
  logic              do_push;
  logic              do_pop;

  assign empty_o    = (wr_q == rd_q);
  assign full_o     = (wr_q[QPTR_W] != rd_q[QPTR_W]) &&
                      (wr_q[QPTR_W-1:0] == rd_q[QPTR_W-1:0]);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q[QPTR_W-1:0]];
  assign wr_d       = do_push ? wr_q + (QPTR_W+1)'(1) : wr_q;
  assign rd_d       = do_pop ? rd_q + (QPTR_W+1)'(1) : rd_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[QPTR_W-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  `PEPD_ASSERT(a_no_overflow, !(push_i && full_o), "beat pushed into full queue")
  `PEPD_ASSERT(a_fill_bound, (wr_q - rd_q) <= (QPTR_W+1)'(QUEUE_DEPTH), "queue fill out of range")

endmodule

### src/pepd_back.sv
// back end: packet state, sequence gap and result register
`timescale 1ns / 1ps
`include "photon_event_packet_deframer_macros.svh"
module pepd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pepd_pkg::cmd_t               cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic                         kind_o,
  output logic [pepd_pkg::COORD_W-1:0] x_pos_o,
  output logic [pepd_pkg::COORD_W-1:0] y_pos_o,
  output logic [pepd_pkg::WORD_W-1:0]  pulse_o,
  output logic [pepd_pkg::WORD_W-1:0]  missed_o,
  output logic [pepd_pkg::COUNT_W-1:0] photons_o,
  output logic                         clamped_o
);
  import pepd_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               clamp_q, clamp_d;
  logic [WORD_W-1:0]  expect_q, expect_d;
  logic [WORD_W-1:0]  gap_q, gap_d;
  logic [COORD_W-1:0] hx_q, hx_d;
  logic [COORD_W-1:0] hy_q, hy_d;

  logic               out_vld_q, out_vld_d;
  logic               kind_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [WORD_W-1:0]  pulse_q, missed_q;
  logic [COUNT_W-1:0] photons_q;
  logic               clamped_q;

  logic               slot_free;
  logic               take;
  logic               photon;
  logic               res_vld;

  assign slot_free = !out_vld_q || pop_i;
  assign take      = !cmd_empty_i && slot_free;
  assign cmd_pop_o = take;

  always_comb begin
    count_d  = count_q;
    clamp_d  = clamp_q;
    gap_d    = gap_q;
    hx_d     = hx_q;
    hy_d     = hy_q;
    if (take) begin
      unique case (cmd_i.op)
        OP_COUNT: begin
          if (cmd_i.word > WORD_W'(CAPACITY)) begin
            count_d = COUNT_W'(CAPACITY);
            clamp_d = 1'b1;
          end else begin
            count_d = cmd_i.word[COUNT_W-1:0];
            clamp_d = 1'b0;
          end
        end
        OP_SEQ:   gap_d = cmd_i.word - expect_q;
        OP_X:     hx_d  = cmd_i.word[COORD_W:1];
        OP_Y:     hy_d  = cmd_i.word[COORD_W:1];
        OP_SKIP, OP_PULSE: ;
        default:  ;
      endcase
    end
  end

  // only rows inside the header count give an event
  assign photon  = (cmd_i.op == OP_PULSE) && (CMP_W'(cmd_i.row) <= CMP_W'(count_d));
  assign res_vld = cmd_i.last || photon;

  assign expect_d  = (take && cmd_i.last) ? expect_q + gap_d + WORD_W'(1) : expect_q;
  assign out_vld_d = take ? res_vld : (pop_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i) begin
    if (take && res_vld) begin
      kind_q    <= cmd_i.last;
      x_q       <= photon ? hx_d : '0;
      y_q       <= photon ? hy_d : '0;
      pulse_q   <= photon ? cmd_i.word : '0;
      missed_q  <= cmd_i.last ? gap_d : '0;
      photons_q <= count_d;
      clamped_q <= clamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      clamp_q   <= 1'b0;
      expect_q  <= '0;
      gap_q     <= '0;
      hx_q      <= '0;
      hy_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      clamp_q   <= clamp_d;
      expect_q  <= expect_d;
      gap_q     <= gap_d;
      hx_q      <= hx_d;
      hy_q      <= hy_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty_o   = !out_vld_q;
  assign kind_o    = kind_q;
  assign x_pos_o   = x_q;
  assign y_pos_o   = y_q;
  assign pulse_o   = pulse_q;
  assign missed_o  = missed_q;
  assign photons_o = photons_q;
  assign clamped_o = clamped_q;

  `PEPD_ASSERT(a_clamp_cap, !clamp_q || (count_q == COUNT_W'(CAPACITY)),
               "clamp flag without count at capacity")
  `PEPD_ASSERT_NEXT(a_event_no_gap, take && res_vld && !cmd_i.last, missed_q == '0,
                    "photon event carries a sequence gap")

endmodule
